FILE: sv/address_list_tokenizer_macros.svh
// Assertion macros for the address list tokenizer.
`ifndef ADDRESS_LIST_TOKENIZER_MACROS_SVH
`define ADDRESS_LIST_TOKENIZER_MACROS_SVH

`ifndef SYNTHESIS
`define ALT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ALT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ALT_ASSERT(label, prop, msg)
`define ALT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: sv/alt_pkg.sv
// Shared types, character codes and helpers for the address list tokenizer.
package alt_pkg;

  localparam int DefaultMaxCommentDepth = 15;
  localparam int DepthWidth = 4;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;

  typedef enum logic [1:0] {
    ACT_DROP   = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_COMMIT = 2'd3
  } alt_action_e;

  typedef struct packed {
    logic                  in_escape;
    logic                  in_quote;
    logic [DepthWidth-1:0] comment_depth;
    logic                  in_bracket;
    logic                  buffer_nonempty;
    logic                  error_seen;
  } alt_state_t;

  typedef struct packed {
    alt_action_e action;
    logic [7:0]  char_out;
    logic        parse_error;
    logic        list_end;
  } alt_result_t;

  // The depth counter saturates the usable limit at its own range.
  function automatic logic [DepthWidth-1:0] alt_depth_limit(input int max_depth);
    logic [DepthWidth-1:0] lim;
    if (max_depth > (2 ** DepthWidth) - 1) begin
      lim = '1;
    end else begin
      lim = DepthWidth'(max_depth);
    end
    return lim;
  endfunction

endpackage

FILE: sv/alt_classify.sv
// Per-byte classifier: next tokenizer state and the tag for one byte.
module alt_classify import alt_pkg::*; #(
  parameter int MaxCommentDepth = DefaultMaxCommentDepth
) (
  input  alt_state_t  state_i,
  input  logic [7:0]  char_i,
  input  logic        last_i,
  output alt_state_t  state_d_o,
  output alt_result_t result_o
);

  localparam logic [DepthWidth-1:0] DepthLimit = alt_depth_limit(MaxCommentDepth);

  alt_state_t  nxt;
  alt_action_e act;

  always_comb begin
    nxt = state_i;
    act = ACT_DROP;
    if (state_i.error_seen) begin
      act = ACT_DROP;
    end else if (state_i.in_escape) begin
      nxt.in_escape = 1'b0;
      if (char_i == ChTab || char_i == ChLf) begin
        nxt.error_seen = 1'b1;
      end else begin
        nxt.buffer_nonempty = 1'b1;
        act = ACT_APPEND;
      end
    end else if (state_i.in_quote) begin
      if (char_i == ChQuote) begin
        nxt.in_quote = 1'b0;
      end else if (char_i == ChBslash) begin
        nxt.in_escape = 1'b1;
      end
      nxt.buffer_nonempty = 1'b1;
      act = ACT_APPEND;
    end else if (state_i.comment_depth != '0) begin
      // inside a comment everything is dropped; only parens count
      if (char_i == ChLparen) begin
        if (state_i.comment_depth >= DepthLimit) begin
          nxt.error_seen = 1'b1;
        end else begin
          nxt.comment_depth = state_i.comment_depth + DepthWidth'(1);
        end
      end else if (char_i == ChRparen) begin
        nxt.comment_depth = state_i.comment_depth - DepthWidth'(1);
      end
    end else begin
      unique case (char_i)
        ChSpace, ChTab, ChLf: act = ACT_DROP;
        ChLparen: nxt.comment_depth = DepthWidth'(1);
        ChRparen: nxt.error_seen = 1'b1;
        ChLt: begin
          nxt.in_bracket      = 1'b1;
          nxt.buffer_nonempty = 1'b0;
          act                 = ACT_CLEAR;
        end
        ChGt: begin
          if (!state_i.in_bracket) begin
            nxt.error_seen = 1'b1;
          end else begin
            nxt.in_bracket = 1'b0;
            if (state_i.buffer_nonempty) begin
              nxt.buffer_nonempty = 1'b0;
              act                 = ACT_COMMIT;
            end
          end
        end
        ChColon: begin
          nxt.buffer_nonempty = 1'b0;
          act                 = ACT_CLEAR;
        end
        ChComma, ChSemi: begin
          if (state_i.buffer_nonempty) begin
            nxt.buffer_nonempty = 1'b0;
            act                 = ACT_COMMIT;
          end
        end
        ChQuote: begin
          nxt.in_quote        = 1'b1;
          nxt.buffer_nonempty = 1'b1;
          act                 = ACT_APPEND;
        end
        ChBslash: begin
          nxt.in_escape       = 1'b1;
          nxt.buffer_nonempty = 1'b1;
          act                 = ACT_APPEND;
        end
        default: begin
          nxt.buffer_nonempty = 1'b1;
          act                 = ACT_APPEND;
        end
      endcase
    end
  end

  assign result_o.action      = act;
  assign result_o.char_out    = (act == ACT_APPEND) ? char_i : 8'h00;
  assign result_o.parse_error = nxt.error_seen;
  assign result_o.list_end    = last_i;

  // last byte of a list returns everything to reset
  assign state_d_o = last_i ? alt_state_t'('0) : nxt;

endmodule

FILE: sv/alt_outbuf.sv
// Two-entry result buffer: output register plus skid register.
module alt_outbuf import alt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  alt_result_t result_i,
  output logic        valid_o,
  input  logic        stall_i,
  output alt_result_t result_o
);

  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;
  alt_result_t out_q, out_d;
  alt_result_t skid_q, skid_d;
  logic        accept, take;

  assign stall_o = skid_valid_q;
  assign accept  = valid_i && !skid_valid_q;
  assign take    = out_valid_q && !stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || take) begin
        out_d       = result_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = result_i;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign valid_o  = out_valid_q;
  assign result_o = out_q;

endmodule

FILE: sv/address_list_tokenizer.sv
// Top level of the address list tokenizer.
// Takes one byte of a mail address list per request and returns one tag per byte:
// drop, append, clear buffer or commit. A byte is taken every cycle while stall_o is low; its
// tag goes into the output register when that is free or being read, and otherwise waits
// in the skid register. The scan state (escape, quote, comment depth, bracket, buffer fill,
// sticky error) is updated as the byte is accepted, and results pass through a two-entry
// output buffer, so stall_o rises only when both the output register and the skid
// register are occupied. The byte flagged with last_byte_i returns all state, including
// the error, to reset.
`include "address_list_tokenizer_macros.svh"

module address_list_tokenizer import alt_pkg::*; #(
  parameter int MaxCommentDepth = DefaultMaxCommentDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [7:0] char_in_i,
  input  logic       last_byte_i,
  output logic       valid_o,
  input  logic       stall_i,
  output logic [1:0] action_o,
  output logic [7:0] char_out_o,
  output logic       parse_error_o,
  output logic       list_end_o
);

  localparam logic [DepthWidth-1:0] DepthLimit = alt_depth_limit(MaxCommentDepth);

  alt_state_t  state_q, state_d;
  alt_result_t result, result_out;
  logic        accept;
  logic        last_accept;

  assign accept      = valid_i && !stall_o;
  assign last_accept = accept && last_byte_i;

  alt_classify #(
    .MaxCommentDepth(MaxCommentDepth)
  ) u_classify (
    .state_i  (state_q),
    .char_i   (char_in_i),
    .last_i   (last_byte_i),
    .state_d_o(state_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  alt_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .result_i(result),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .result_o(result_out)
  );

  assign action_o      = result_out.action;
  assign char_out_o    = result_out.char_out;
  assign parse_error_o = result_out.parse_error;
  assign list_end_o    = result_out.list_end;

  `ALT_ASSERT_ALWAYS(a_skid_behind_out, stall_o |-> valid_o, "skid full with empty output")
  `ALT_ASSERT(a_last_resets, last_accept |=> (state_q == '0), "state not cleared")
  `ALT_ASSERT(a_error_sticky, state_q.error_seen && !last_accept |=> state_q.error_seen, "error lost")
  `ALT_ASSERT(a_depth_bound, state_q.comment_depth <= DepthLimit, "comment depth over limit")

endmodule

FILE: bench/address_list_checker.sv
// Checker for the address list tokenizer: predicts the tag of each request and compares.
module address_list_checker import alt_pkg::*; #(
  parameter int MaxCommentDepth = DefaultMaxCommentDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  input  logic       req_stall_i,
  input  logic [7:0] char_in_i,
  input  logic       last_byte_i,
  input  logic       tag_valid_i,
  input  logic       tag_stall_i,
  input  logic [1:0] action_i,
  input  logic [7:0] char_out_i,
  input  logic       parse_error_i,
  input  logic       list_end_i,
  output int         mismatches_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DepthMax = (2 ** DepthWidth) - 1;
  // the 4-bit counter caps nesting even if the parameter allows more
  localparam int DepthCap = (MaxCommentDepth > DepthMax) ? DepthMax : MaxCommentDepth;

  alt_state_t  scan = '0;
  alt_result_t tag_q[$];
  int          mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    $display("%0t: %s: expected %0h, got %0h", $time, what, want_v, got_v);
    mismatch_count++;
  endtask

  function automatic alt_action_e scan_byte(input logic [7:0] ch);
    if (scan.error_seen) return ACT_DROP;
    if (scan.in_escape) begin
      scan.in_escape = 1'b0;
      if (ch == ChTab || ch == ChLf) begin
        scan.error_seen = 1'b1;
        return ACT_DROP;
      end
      scan.buffer_nonempty = 1'b1;
      return ACT_APPEND;
    end
    if (scan.in_quote) begin
      if (ch == ChQuote) begin
        scan.in_quote = 1'b0;
      end else if (ch == ChBslash) begin
        scan.in_escape = 1'b1;
      end
      scan.buffer_nonempty = 1'b1;
      return ACT_APPEND;
    end
    // inside a comment quotes and backslashes mean nothing
    if (scan.comment_depth != '0) begin
      if (ch == ChLparen) begin
        if (int'(scan.comment_depth) >= DepthCap) begin
          scan.error_seen = 1'b1;
        end else begin
          scan.comment_depth = scan.comment_depth + DepthWidth'(1);
        end
      end else if (ch == ChRparen) begin
        scan.comment_depth = scan.comment_depth - DepthWidth'(1);
      end
      return ACT_DROP;
    end
    case (ch)
      ChSpace, ChTab, ChLf: begin
        return ACT_DROP;
      end
      ChLparen: begin
        scan.comment_depth = DepthWidth'(1);
        return ACT_DROP;
      end
      ChRparen: begin
        scan.error_seen = 1'b1;
        return ACT_DROP;
      end
      ChLt: begin
        scan.in_bracket = 1'b1;
        scan.buffer_nonempty = 1'b0;
        return ACT_CLEAR;
      end
      ChGt: begin
        if (!scan.in_bracket) begin
          scan.error_seen = 1'b1;
          return ACT_DROP;
        end
        scan.in_bracket = 1'b0;
        if (!scan.buffer_nonempty) return ACT_DROP;
        scan.buffer_nonempty = 1'b0;
        return ACT_COMMIT;
      end
      ChColon: begin
        scan.buffer_nonempty = 1'b0;
        return ACT_CLEAR;
      end
      ChComma, ChSemi: begin
        if (!scan.buffer_nonempty) return ACT_DROP;
        scan.buffer_nonempty = 1'b0;
        return ACT_COMMIT;
      end
      ChQuote: begin
        scan.in_quote = 1'b1;
        scan.buffer_nonempty = 1'b1;
        return ACT_APPEND;
      end
      ChBslash: begin
        scan.in_escape = 1'b1;
        scan.buffer_nonempty = 1'b1;
        return ACT_APPEND;
      end
      default: begin
        scan.buffer_nonempty = 1'b1;
        return ACT_APPEND;
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    alt_result_t want;
    if (rst_ni) begin
      // push before pop so the queue order holds when both fire on one edge
      if (req_valid_i && !req_stall_i) begin
        want.action      = scan_byte(char_in_i);
        want.char_out    = (want.action == ACT_APPEND) ? char_in_i : 8'h00;
        want.parse_error = scan.error_seen;
        want.list_end    = last_byte_i;
        if (last_byte_i) scan = '0;
        tag_q.push_back(want);
      end
      if (tag_valid_i && !tag_stall_i) begin
        if (tag_q.size() == 0) begin
          report_mismatch("tag with no request pending", 0, int'(action_i));
        end else begin
          want = tag_q.pop_front();
          if (action_i !== want.action) begin
            report_mismatch("action", int'(want.action), int'(action_i));
          end
          if (char_out_i !== want.char_out) begin
            report_mismatch("char_out", int'(want.char_out), int'(char_out_i));
          end
          if (parse_error_i !== want.parse_error) begin
            report_mismatch("parse_error", int'(want.parse_error), int'(parse_error_i));
          end
          if (list_end_i !== want.list_end) begin
            report_mismatch("list_end", int'(want.list_end), int'(list_end_i));
          end
        end
      end
    end
    pending_o <= tag_q.size();
  end

endmodule

FILE: bench/address_list_tokenizer_test.sv
// Testbench top for the address list tokenizer: clock, reset, stimulus and verdict.
module address_list_tokenizer_test import alt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PhaseBytes = 225;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       valid_i;
  logic       stall_o;
  logic [7:0] char_in_i;
  logic       last_byte_i;
  logic       valid_o;
  logic       stall_i;
  logic [1:0] action_o;
  logic [7:0] char_out_o;
  logic       parse_error_o;
  logic       list_end_o;

  int mismatches;
  int pending;

  int         idle_pct = 0;
  int         stall_pct = 0;
  bit         pressure_req = 1'b0;
  bit         pressure_done = 1'b0;
  int         bytes_sent = 0;
  logic [7:0] list_q[$];

  always #10 clk_i = ~clk_i;

  address_list_tokenizer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .char_in_i    (char_in_i),
    .last_byte_i  (last_byte_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .action_o     (action_o),
    .char_out_o   (char_out_o),
    .parse_error_o(parse_error_o),
    .list_end_o   (list_end_o)
  );

  address_list_checker tag_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (valid_i),
    .req_stall_i  (stall_o),
    .char_in_i    (char_in_i),
    .last_byte_i  (last_byte_i),
    .tag_valid_i  (valid_o),
    .tag_stall_i  (stall_i),
    .action_i     (action_o),
    .char_out_i   (char_out_o),
    .parse_error_i(parse_error_o),
    .list_end_i   (list_end_o),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Offers one request and holds it until taken; valid stays high between
  // back-to-back requests.
  task automatic send_byte(input logic [7:0] ch, input logic last);
    if ($urandom_range(99) < idle_pct) begin
      valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    valid_i     <= 1'b1;
    char_in_i   <= ch;
    last_byte_i <= last;
    do @(posedge clk_i); while (stall_o);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit ends_list);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], ends_list && (i == s.len() - 1));
    end
  endtask

  function automatic void push_word();
    int len;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        6, 7:    list_q.push_back(8'(8'h30 + $urandom_range(9)));
        8:       list_q.push_back($urandom_range(1) ? 8'h2E : 8'h2D);
        9:       list_q.push_back(8'($urandom_range(128, 255)));
        default: list_q.push_back(8'(8'h61 + $urandom_range(25)));
      endcase
    end
  endfunction

  // receiver: random stalls, plus one long hold-off to back up the block
  initial begin
    stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pressure_req && !pressure_done) begin
        stall_i <= 1'b1;
        repeat (60) @(posedge clk_i);
        pressure_done = 1'b1;
      end else begin
        stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    int n;
    int d;
    rst_ni      <= 1'b0;
    valid_i     <= 1'b0;
    char_in_i   <= 8'h00;
    last_byte_i <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed lists
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text(",;", 1'b0);
    send_text("\"a\\\"b\"@c", 1'b0);
    send_text("(x(\")) g:<", 1'b0);
    send_text("\\\t>", 1'b1);
    send_text("<\\z>", 1'b1);
    send_text("\\\n", 1'b1);
    send_text("<>)", 1'b1);
    send_text(">\n", 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          pressure_req = 1'b1;
        end
        1: begin
          idle_pct = 74;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 74;
        end
        default: begin
          idle_pct = 28;
          stall_pct = 28;
        end
      endcase
      while (bytes_sent < 34 + (ph + 1) * PhaseBytes) begin
        list_q.delete();
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
          case ($urandom_range(9))
            0, 1, 2: begin
              push_word();
              list_q.push_back("@");
              push_word();
            end
            3, 4: begin
              push_word();
              list_q.push_back(ChSpace);
              list_q.push_back(ChLt);
              push_word();
              list_q.push_back("@");
              push_word();
              list_q.push_back(ChGt);
            end
            5: begin
              list_q.push_back(ChQuote);
              push_word();
              if ($urandom_range(1)) begin
                list_q.push_back(ChBslash);
                list_q.push_back(8'($urandom_range(255)));
              end
              push_word();
              list_q.push_back(ChQuote);
              list_q.push_back("@");
              push_word();
            end
            6: begin
              push_word();
              list_q.push_back(ChColon);
              push_word();
              list_q.push_back("@");
              push_word();
              list_q.push_back(ChComma);
              push_word();
              list_q.push_back(ChSemi);
            end
            7: begin
              // mostly shallow comments, now and then near, at or past the depth cap
              d = ($urandom_range(5) == 0) ? $urandom_range(14, 17) : $urandom_range(1, 3);
              repeat (d) list_q.push_back(ChLparen);
              push_word();
              repeat (d) list_q.push_back(ChRparen);
              push_word();
              list_q.push_back("@");
              push_word();
            end
            8: begin
              repeat ($urandom_range(1, 6)) list_q.push_back(8'($urandom_range(255)));
            end
            default: begin
              push_word();
              list_q.push_back(ChBslash);
              case ($urandom_range(3))
                0:       list_q.push_back(ChTab);
                1:       list_q.push_back(ChLf);
                default: list_q.push_back(8'($urandom_range(255)));
              endcase
              push_word();
            end
          endcase
          case ($urandom_range(3))
            0: list_q.push_back(ChComma);
            1: list_q.push_back(ChSemi);
            2: begin
              list_q.push_back(ChComma);
              list_q.push_back(ChSpace);
            end
            default: ;
          endcase
        end
        for (int i = 0; i < list_q.size(); i++) begin
          send_byte(list_q[i], i == list_q.size() - 1);
        end
      end
    end

    valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
